// ===== hdl/wsfd_pkg.sv =====
// Package for the WebSocket frame deframer: parse phases, result kinds,
// error codes, close codes, opcodes and the result record.
// No dependencies.
package wsfd_pkg;

    // Width of the extended length accumulator (64-bit big-endian length).
    localparam int LEN_BITS = 64;

    // Largest payload length allowed on a control frame.
    localparam logic [6:0] CTRL_MAX_LEN = 7'd125;

    // Length codes in the second header byte that announce an extended length.
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // Extended length byte counts.
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    // Reset value of the frame size limit.
    localparam logic [31:0] MAX_FRAME_RESET = 32'd16777216;

    // Configuration register indexes.
    localparam logic CFG_COMPRESSION = 1'b0;
    localparam logic CFG_MAX_FRAME   = 1'b1;

    // Close codes.
    localparam logic [9:0] CLOSE_NONE     = 10'd0;
    localparam logic [9:0] CLOSE_PROTOCOL = 10'd1002;
    localparam logic [9:0] CLOSE_TOO_BIG  = 10'd1009;

    // Opcodes that the deframer supports.
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    typedef enum logic [1:0] {
        PH_FIRST   = 2'd0,
        PH_SECOND  = 2'd1,
        PH_EXT     = 2'd2,
        PH_PAYLOAD = 2'd3
    } wsfd_phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2,
        KIND_IGNORED = 2'd3
    } wsfd_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_RSV       = 3'd1,
        ERR_FRAG_CTRL = 3'd2,
        ERR_MASKED    = 3'd3,
        ERR_CTRL_LONG = 3'd4,
        ERR_TOO_LONG  = 3'd5,
        ERR_BAD_OP    = 3'd6
    } wsfd_err_t;

    // One result item as held in the output register.
    typedef struct packed {
        wsfd_kind_t  kind;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_opcode;
        logic        final_fragment;
        logic        compressed_flag;
        logic        header_end;
        logic [31:0] frame_length;
        logic        frame_last;
        wsfd_err_t   error_kind;
        logic [9:0]  close_status;
    } wsfd_result_t;

    // True for an opcode that the deframer does not support.
    function automatic logic opcode_bad(input logic [3:0] op);
        logic bad;
        case (op) inside
            OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: bad = 1'b0;
            default: bad = 1'b1;
        endcase
        return bad;
    endfunction

    // Close code that goes with an error.
    function automatic logic [9:0] close_for(input wsfd_err_t err);
        logic [9:0] code;
        case (err)
            ERR_NONE:     code = CLOSE_NONE;
            ERR_TOO_LONG: code = CLOSE_TOO_BIG;
            default:      code = CLOSE_PROTOCOL;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/websocket_frame_deframer_unit.sv =====
// An item is taken into the input register and processed into the result register
// once the result register can take it; the result is then offered from that register.
// Throughput: one byte per cycle while results are taken; one parse step between the registers.
// A full result register does not stop the input register from taking the next item
// while the result is being taken in the same cycle.
// Reset: asynchronous, active low; parser returns to the first header byte, no error.
//
// WebSocket frame deframer top level: header parse, payload pass-through and checks.
// Depends on wsfd_pkg.
module websocket_frame_deframer_unit #(
    parameter int PAYLOAD_COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    // Output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [3:0]  frame_opcode,
    output logic        final_fragment,
    output logic        compressed_flag,
    output logic        header_end,
    output logic [31:0] frame_length,
    output logic        frame_last,
    output logic [2:0]  error_kind,
    output logic [9:0]  close_status
);
    import wsfd_pkg::*;

    // Configuration registers
    logic        comp_en_reg;
    logic [31:0] max_frame_reg;

    // Input and output stage
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    wsfd_result_t out_reg;
    wsfd_result_t res_next;
    logic         proc;

    // Parser state
    wsfd_phase_t                   phase_reg, phase_next;
    logic [3:0]                    ext_left_reg, ext_left_next;
    logic [LEN_BITS-1:0]           acc_reg, acc_next;
    logic [PAYLOAD_COUNT_BITS-1:0] left_reg, left_next;
    logic [3:0]                    op_reg, op_next;
    logic                          fin_reg, fin_next;
    logic                          rsv1_reg, rsv1_next;
    wsfd_err_t                     err_reg, err_next;

    // The item in the input register is processed when the result register can take it.
    assign proc     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || proc;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_en_reg   <= 1'b0;
            max_frame_reg <= MAX_FRAME_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COMPRESSION: comp_en_reg   <= cfg_data[0];
                CFG_MAX_FRAME:   max_frame_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
        end
    end

    // Parser state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            ext_left_reg  <= '0;
            acc_reg       <= '0;
            left_reg      <= '0;
            op_reg        <= '0;
            fin_reg       <= 1'b0;
            rsv1_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (proc)
            begin
                phase_reg    <= phase_next;
                ext_left_reg <= ext_left_next;
                acc_reg      <= acc_next;
                left_reg     <= left_next;
                op_reg       <= op_next;
                fin_reg      <= fin_next;
                rsv1_reg     <= rsv1_next;
                err_reg      <= err_next;
            end
            if (proc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_reg <= res_next;
        end
    end

    // One parse step: next state and the result item for the byte in the input register.
    always_comb
    begin
        logic      do_finish;
        logic      raise;
        wsfd_err_t raise_code;

        phase_next    = phase_reg;
        ext_left_next = ext_left_reg;
        acc_next      = acc_reg;
        left_next     = left_reg;
        op_next       = op_reg;
        fin_next      = fin_reg;
        rsv1_next     = rsv1_reg;
        err_next      = err_reg;
        do_finish     = 1'b0;
        raise         = 1'b0;
        raise_code    = ERR_NONE;

        res_next              = '0;
        res_next.kind         = KIND_HEADER;
        res_next.error_kind   = ERR_NONE;

        if (err_reg != ERR_NONE)
        begin
            res_next.kind       = KIND_IGNORED;
            res_next.error_kind = err_reg;
        end
        else
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    fin_next  = in_byte_reg[7];
                    rsv1_next = in_byte_reg[6];
                    op_next   = in_byte_reg[3:0];
                    if ((in_byte_reg[6] && !comp_en_reg) || (|in_byte_reg[5:4]))
                    begin
                        raise      = 1'b1;
                        raise_code = ERR_RSV;
                    end
                    else if (in_byte_reg[3] && !in_byte_reg[7])
                    begin
                        raise      = 1'b1;
                        raise_code = ERR_FRAG_CTRL;
                    end
                    else
                    begin
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    if (in_byte_reg[7])
                    begin
                        raise      = 1'b1;
                        raise_code = ERR_MASKED;
                    end
                    else if (in_byte_reg[6:0] == LEN7_EXT16 ||
                             in_byte_reg[6:0] == LEN7_EXT64)
                    begin
                        acc_next      = '0;
                        ext_left_next = (in_byte_reg[6:0] == LEN7_EXT16) ?
                                        EXT16_BYTES : EXT64_BYTES;
                        phase_next    = PH_EXT;
                    end
                    else
                    begin
                        acc_next  = LEN_BITS'(in_byte_reg[6:0]);
                        do_finish = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    // Big-endian: each byte shifts in at the bottom.
                    acc_next      = {acc_reg[LEN_BITS-9:0], in_byte_reg};
                    ext_left_next = ext_left_reg - 4'd1;
                    do_finish     = (ext_left_reg == 4'd1);
                end
                PH_PAYLOAD:
                begin
                    left_next             = left_reg - PAYLOAD_COUNT_BITS'(1);
                    res_next.kind         = KIND_PAYLOAD;
                    res_next.payload_byte = in_byte_reg;
                    if (left_reg == PAYLOAD_COUNT_BITS'(1))
                    begin
                        phase_next          = PH_FIRST;
                        res_next.frame_last = 1'b1;
                        if (opcode_bad(op_reg))
                        begin
                            raise      = 1'b1;
                            raise_code = ERR_BAD_OP;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase

            // End of header: length checks, then entry to the payload, or back to the first byte if empty.
            if (do_finish)
            begin
                if (op_reg[3] && acc_next > LEN_BITS'(CTRL_MAX_LEN))
                begin
                    raise      = 1'b1;
                    raise_code = ERR_CTRL_LONG;
                end
                else if (!op_reg[3] && (acc_next > LEN_BITS'(max_frame_reg) ||
                         (|acc_next[LEN_BITS-1:PAYLOAD_COUNT_BITS])))
                begin
                    raise      = 1'b1;
                    raise_code = ERR_TOO_LONG;
                end
                else if (acc_next == '0)
                begin
                    phase_next          = PH_FIRST;
                    res_next.header_end = 1'b1;
                    res_next.frame_last = 1'b1;
                    if (opcode_bad(op_reg))
                    begin
                        raise      = 1'b1;
                        raise_code = ERR_BAD_OP;
                    end
                end
                else
                begin
                    left_next             = acc_next[PAYLOAD_COUNT_BITS-1:0];
                    phase_next            = PH_PAYLOAD;
                    res_next.header_end   = 1'b1;
                    res_next.frame_length = acc_next[31:0];
                end
            end

            // A new error: payload byte cleared; position marks kept only for a bad opcode.
            if (raise)
            begin
                err_next              = raise_code;
                res_next.kind         = KIND_ERROR;
                res_next.payload_byte = '0;
                res_next.error_kind   = raise_code;
                if (raise_code != ERR_BAD_OP)
                begin
                    res_next.header_end   = 1'b0;
                    res_next.frame_length = '0;
                    res_next.frame_last   = 1'b0;
                end
            end
        end

        res_next.frame_opcode    = op_next;
        res_next.final_fragment  = fin_next;
        res_next.compressed_flag = rsv1_next;
        res_next.close_status    = close_for(res_next.error_kind);
    end

    // Output ports.
    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign payload_byte    = out_reg.payload_byte;
    assign frame_opcode    = out_reg.frame_opcode;
    assign final_fragment  = out_reg.final_fragment;
    assign compressed_flag = out_reg.compressed_flag;
    assign header_end      = out_reg.header_end;
    assign frame_length    = out_reg.frame_length;
    assign frame_last      = out_reg.frame_last;
    assign error_kind      = out_reg.error_kind;
    assign close_status    = out_reg.close_status;

    // A stored error never changes until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ERR_NONE |=> err_reg == $past(err_reg))
        else $error("sticky error changed");

    // An error result always leaves the error stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc && res_next.kind == KIND_ERROR |=> err_reg != ERR_NONE)
        else $error("error raised without being stored");

    // The payload phase always has bytes left to count.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD && err_reg == ERR_NONE |-> left_reg != '0)
        else $error("payload phase with no bytes left");

    // The extended length phase always has bytes left to gather while no error is stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_EXT && err_reg == ERR_NONE |-> ext_left_reg != 4'd0)
        else $error("extended length phase with no bytes left");

endmodule

// ===== bench/wsfd_result_checker.sv =====
// Result checker for the WebSocket frame deframer: watches both channels and the register
// port, predicts one result per accepted byte and compares it with what the block returns.
// Depends on wsfd_pkg.
module wsfd_result_checker #(
    parameter int PAYLOAD_COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  payload_byte,
    input  logic [3:0]  frame_opcode,
    input  logic        final_fragment,
    input  logic        compressed_flag,
    input  logic        header_end,
    input  logic [31:0] frame_length,
    input  logic        frame_last,
    input  logic [2:0]  error_kind,
    input  logic [9:0]  close_status,
    output int          mismatch_count,
    output int          awaiting,
    output int          results_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    import wsfd_pkg::*;

    // Largest length that the payload counter of the block can hold.
    localparam logic [63:0] COUNT_CAP = (64'd1 << PAYLOAD_COUNT_BITS) - 64'd1;

    // Register copies.
    logic        comp_enabled;
    logic [31:0] max_frame;

    // Parser state of the prediction.
    wsfd_phase_t rx_phase;
    logic [3:0]  ext_left;
    logic [63:0] len_acc;
    logic [63:0] pay_left;
    logic [3:0]  cur_opcode;
    logic        cur_fin;
    logic        cur_rsv1;
    wsfd_err_t   held_error;

    wsfd_result_t predicted_results[$];
    wsfd_result_t want;
    wsfd_result_t got;

    initial
    begin
        mismatch_count = 0;
        awaiting = 0;
        results_checked = 0;
    end

    // True for the six opcodes that the deframer handles.
    function automatic logic op_known(input logic [3:0] op);
        case (op)
            OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Length checks and the hand-over to the payload once the header is complete.
    function automatic wsfd_result_t close_header();
        wsfd_result_t r;
        r = '0;
        r.kind = KIND_HEADER;
        if (cur_opcode[3] && len_acc > CTRL_MAX_LEN)
        begin
            held_error = ERR_CTRL_LONG;
            r.kind = KIND_ERROR;
            r.error_kind = ERR_CTRL_LONG;
        end
        else if (!cur_opcode[3] && (len_acc > {32'd0, max_frame} || len_acc > COUNT_CAP))
        begin
            held_error = ERR_TOO_LONG;
            r.kind = KIND_ERROR;
            r.error_kind = ERR_TOO_LONG;
        end
        else if (len_acc == 64'd0)
        begin
            rx_phase = PH_FIRST;
            r.header_end = 1'b1;
            r.frame_last = 1'b1;
            if (!op_known(cur_opcode))
            begin
                held_error = ERR_BAD_OP;
                r.kind = KIND_ERROR;
                r.error_kind = ERR_BAD_OP;
            end
        end
        else
        begin
            pay_left = len_acc & COUNT_CAP;
            rx_phase = PH_PAYLOAD;
            r.header_end = 1'b1;
            r.frame_length = len_acc[31:0];
        end
        return r;
    endfunction

    // Result that one received byte should give; advances the parser state.
    function automatic wsfd_result_t deframe_byte(input logic [7:0] b);
        wsfd_result_t r;
        r = '0;
        r.kind = KIND_HEADER;
        if (held_error != ERR_NONE)
        begin
            r.kind = KIND_IGNORED;
            r.error_kind = held_error;
        end
        else
        begin
            case (rx_phase)
                PH_SECOND:
                begin
                    if (b[7])
                    begin
                        held_error = ERR_MASKED;
                        r.kind = KIND_ERROR;
                        r.error_kind = ERR_MASKED;
                    end
                    else if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64)
                    begin
                        len_acc = 64'd0;
                        ext_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        rx_phase = PH_EXT;
                    end
                    else
                    begin
                        len_acc = {57'd0, b[6:0]};
                        r = close_header();
                    end
                end
                PH_EXT:
                begin
                    len_acc = {len_acc[55:0], b};
                    if (ext_left != 4'd0)
                        ext_left = ext_left - 4'd1;
                    if (ext_left == 4'd0)
                        r = close_header();
                end
                PH_PAYLOAD:
                begin
                    if (pay_left != 64'd0)
                        pay_left = pay_left - 64'd1;
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = b;
                    if (pay_left == 64'd0)
                    begin
                        rx_phase = PH_FIRST;
                        r.frame_last = 1'b1;
                        // An unsupported opcode is only reported on the last byte.
                        if (!op_known(cur_opcode))
                        begin
                            held_error = ERR_BAD_OP;
                            r.kind = KIND_ERROR;
                            r.payload_byte = 8'd0;
                            r.error_kind = ERR_BAD_OP;
                        end
                    end
                end
                default:
                begin
                    cur_fin = b[7];
                    cur_rsv1 = b[6];
                    cur_opcode = b[3:0];
                    if ((b[6] && !comp_enabled) || b[5:4] != 2'b00)
                    begin
                        held_error = ERR_RSV;
                        r.kind = KIND_ERROR;
                        r.error_kind = ERR_RSV;
                    end
                    else if (b[3] && !b[7])
                    begin
                        held_error = ERR_FRAG_CTRL;
                        r.kind = KIND_ERROR;
                        r.error_kind = ERR_FRAG_CTRL;
                    end
                    else
                        rx_phase = PH_SECOND;
                end
            endcase
        end
        r.frame_opcode = cur_opcode;
        r.final_fragment = cur_fin;
        r.compressed_flag = cur_rsv1;
        if (r.error_kind == ERR_NONE)
            r.close_status = CLOSE_NONE;
        else if (r.error_kind == ERR_TOO_LONG)
            r.close_status = CLOSE_TOO_BIG;
        else
            r.close_status = CLOSE_PROTOCOL;
        return r;
    endfunction

    function automatic string describe(input wsfd_result_t r);
        return {$sformatf("kind=%0d byte=%h op=%h fin=%b rsv1=%b hend=%b len=%0d",
                          r.kind, r.payload_byte, r.frame_opcode, r.final_fragment,
                          r.compressed_flag, r.header_end, r.frame_length),
                $sformatf(" last=%b err=%0d close=%0d",
                          r.frame_last, r.error_kind, r.close_status)};
    endfunction

    // Compare returned items, track register writes and predict accepted items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_enabled = 1'b0;
            max_frame = MAX_FRAME_RESET;
            rx_phase = PH_FIRST;
            ext_left = 4'd0;
            len_acc = 64'd0;
            pay_left = 64'd0;
            cur_opcode = 4'd0;
            cur_fin = 1'b0;
            cur_rsv1 = 1'b0;
            held_error = ERR_NONE;
            predicted_results.delete();
            awaiting = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.kind = wsfd_kind_t'(kind);
                got.payload_byte = payload_byte;
                got.frame_opcode = frame_opcode;
                got.final_fragment = final_fragment;
                got.compressed_flag = compressed_flag;
                got.header_end = header_end;
                got.frame_length = frame_length;
                got.frame_last = frame_last;
                got.error_kind = wsfd_err_t'(error_kind);
                got.close_status = close_status;
                results_checked = results_checked + 1;
                if (predicted_results.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing predicted: %s", $time, describe(got));
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (want.kind !== got.kind || want.payload_byte !== got.payload_byte ||
                        want.frame_opcode !== got.frame_opcode ||
                        want.final_fragment !== got.final_fragment ||
                        want.compressed_flag !== got.compressed_flag ||
                        want.header_end !== got.header_end ||
                        want.frame_length !== got.frame_length ||
                        want.frame_last !== got.frame_last ||
                        want.error_kind !== got.error_kind ||
                        want.close_status !== got.close_status)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: result %0d differs", $time, results_checked);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(got));
                        end
                    end
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_COMPRESSION)
                    comp_enabled = cfg_data[0];
                else
                    max_frame = cfg_data;
            end
            if (in_valid && in_ready)
                predicted_results.insert(predicted_results.size(), deframe_byte(data_byte));
            awaiting = predicted_results.size();
        end
    end

endmodule

// ===== bench/tb_websocket_frame_deframer_unit.sv =====
// Top of the WebSocket frame deframer bench: clock, reset, register writes, byte stream
// stimulus with random idling and the verdict. Depends on wsfd_pkg, the deframer and
// wsfd_result_checker.
module tb_websocket_frame_deframer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import wsfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int NOISE_BYTES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = CFG_COMPRESSION;
    logic [31:0] cfg_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic        final_fragment;
    logic        compressed_flag;
    logic        header_end;
    logic [31:0] frame_length;
    logic        frame_last;
    logic [2:0]  error_kind;
    logic [9:0]  close_status;
    int          mismatch_count;
    int          awaiting;
    int          results_checked;

    // Stimulus bookkeeping and idling controls.
    logic        send_gaps = 1'b1;
    logic        recv_gaps = 1'b1;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    logic        comp_now = 1'b0;
    logic [31:0] max_now = MAX_FRAME_RESET;
    wsfd_err_t   closing_err;
    int unsigned pick;
    int unsigned wide;
    logic [3:0]  bad_op;

    websocket_frame_deframer_unit u_dut (.*);

    wsfd_result_checker #(.PAYLOAD_COUNT_BITS(32)) u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit in case the block stops answering.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off that backs the block up.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            stall_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (recv_gaps && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Offer one byte, possibly after an idle burst; returns on the falling edge after
    // the item has been taken.
    task automatic send_byte(input logic [7:0] b);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent = bytes_sent + 1;
        @(negedge clk);
    endtask

    // One frame; enc 0 uses the shortest length form, 1 forces 16 bits, 2 forces 64 bits.
    task automatic send_frame(input logic fin, input logic rsv1, input logic [3:0] op,
                              input int unsigned len, input int enc);
        logic [63:0] len64;
        int i;
        len64 = {32'd0, len};
        send_byte({fin, rsv1, 2'b00, op});
        if (enc == 0 && len < 126)
            send_byte({1'b0, len64[6:0]});
        else if (enc != 2 && len < 65536)
        begin
            send_byte({1'b0, LEN7_EXT16});
            send_byte(len64[15:8]);
            send_byte(len64[7:0]);
        end
        else
        begin
            send_byte({1'b0, LEN7_EXT64});
            for (i = 7; i >= 0; i--)
                send_byte(len64[8*i +: 8]);
        end
        for (i = 0; i < int'(len); i++)
            send_byte(8'($urandom));
        frames_sent = frames_sent + 1;
    endtask

    // A well-formed frame that the current register setting accepts.
    task automatic random_frame();
        logic [3:0]  op;
        logic        fin;
        logic        rsv1;
        int unsigned len;
        int unsigned limit;
        int unsigned sel;
        int          enc;
        sel = $urandom_range(0, 5);
        case (sel)
            0: op = OP_CONT;
            1: op = OP_TEXT;
            2: op = OP_BINARY;
            3: op = OP_CLOSE;
            4: op = OP_PING;
            default: op = OP_PONG;
        endcase
        fin = op[3] ? 1'b1 : 1'($urandom_range(0, 1));
        rsv1 = comp_now ? 1'($urandom_range(0, 1)) : 1'b0;
        limit = op[3] ? 32'd125 : max_now;
        sel = $urandom_range(0, 15);
        if (sel < 12)
            len = $urandom_range(0, 12);
        else if (sel < 14)
            len = $urandom_range(13, 125);
        else if (sel < 15)
            len = $urandom_range(126, 200);
        else
            len = (limit > 300) ? 300 : limit;
        if (len > limit)
            len = limit;
        enc = $urandom_range(0, 4);
        enc = (enc >= 3) ? enc - 2 : 0;
        if (len >= 126 && enc == 0)
            enc = $urandom_range(1, 2);
        send_frame(fin, rsv1, op, len, enc);
    endtask

    // Change the registers once every predicted result has come back.
    task automatic reconfigure(input logic comp, input logic [31:0] max_bytes);
        in_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        // Bits above the one-bit register go in random and must be dropped.
        cfg_write <= 1'b1;
        cfg_index <= CFG_COMPRESSION;
        cfg_data <= {31'($urandom), comp};
        @(negedge clk);
        cfg_index <= CFG_MAX_FRAME;
        cfg_data <= max_bytes;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        comp_now = comp;
        max_now = max_bytes;
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset setting: every opcode, empty and one-byte
        // payloads, and both long length forms carrying a short length.
        send_frame(1'b1, 1'b0, OP_TEXT, 0, 0);
        send_frame(1'b0, 1'b0, OP_CONT, 1, 1);
        send_frame(1'b1, 1'b0, OP_BINARY, 1, 2);
        send_frame(1'b1, 1'b0, OP_CLOSE, 0, 0);
        send_frame(1'b1, 1'b0, OP_PING, 1, 0);
        send_frame(1'b1, 1'b0, OP_PONG, 0, 0);
        while (bytes_sent < 280)
            random_frame();

        // Compression on and no data payload allowed at all.
        reconfigure(1'b1, 32'd0);
        while (bytes_sent < 530)
            random_frame();

        // Widest limit; the receiver holds off for a long stretch early on.
        reconfigure(1'b1, 32'hFFFF_FFFF);
        send_gaps = 1'b0;
        hold_req <= 1'b1;
        while (bytes_sent < 800)
            random_frame();

        // Small limit without compression, idling switched off for the last part.
        reconfigure(1'b0, 32'($urandom_range(1, 300)));
        send_gaps = 1'b1;
        while (bytes_sent < 960)
            random_frame();
        send_gaps = 1'b0;
        recv_gaps <= 1'b0;
        while (bytes_sent < 1080)
            random_frame();

        // Close the stream on one protocol violation, then bytes that must be ignored.
        closing_err = wsfd_err_t'($urandom_range(1, 6));
        case (closing_err)
            ERR_RSV:
                send_byte({1'b1, 3'($urandom_range(1, 7)), OP_TEXT});
            ERR_FRAG_CTRL:
                send_byte({1'b0, 3'b000, 4'($urandom_range(8, 15))});
            ERR_MASKED:
            begin
                send_byte({1'b1, 3'b000, OP_BINARY});
                send_byte({1'b1, 7'($urandom)});
            end
            ERR_CTRL_LONG:
            begin
                send_byte({1'b1, 3'b000, OP_PING});
                send_byte({1'b0, LEN7_EXT16});
                send_byte(8'd0);
                send_byte(8'($urandom_range(126, 255)));
            end
            ERR_TOO_LONG:
            begin
                send_byte({1'b1, 3'b000, OP_BINARY});
                if ($urandom_range(0, 1) == 1)
                begin
                    wide = $urandom_range(max_now + 1, 65535);
                    send_byte({1'b0, LEN7_EXT16});
                    send_byte(wide[15:8]);
                    send_byte(wide[7:0]);
                end
                else
                begin
                    // Length beyond what the payload counter can hold.
                    send_byte({1'b0, LEN7_EXT64});
                    send_byte(8'($urandom_range(1, 255)));
                    repeat (7) send_byte(8'($urandom));
                end
            end
            default:
            begin
                pick = $urandom_range(3, 12);
                bad_op = (pick > 7) ? 4'(pick + 3) : 4'(pick);
                send_frame(1'b1, 1'b0, bad_op, $urandom_range(0, 3), 0);
            end
        endcase
        repeat (NOISE_BYTES) send_byte(8'($urandom));
        in_valid <= 1'b0;

        while (awaiting != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d bytes in %0d frames under four register settings; %0d compared.",
                 bytes_sent, frames_sent, results_checked);
        $display("Closed on protocol error %0d followed by %0d ignored bytes; %0d mismatches.",
                 closing_err, NOISE_BYTES, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/wsfd_pkg.sv
hdl/websocket_frame_deframer_unit.sv
bench/wsfd_result_checker.sv
bench/tb_websocket_frame_deframer_unit.sv
